### rtl/bfa_pkg.sv
`default_nettype none

package bfa_pkg;

	// default pool geometry
	localparam int DATA_CAPACITY_DEF  = 4096;
	localparam int INODE_CAPACITY_DEF = 1024;
	localparam int WORD_BITS_DEF      = 32;

	// register file
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] REG_DATA_COUNT  = 2'd0;
	localparam logic [1:0] REG_INODE_COUNT = 2'd1;
	localparam logic [1:0] REG_DATA_BASE   = 2'd2;

	localparam logic [12:0] DATA_COUNT_RST  = 13'd4096;
	localparam logic [10:0] INODE_COUNT_RST = 11'd1024;
	localparam logic [31:0] DATA_BASE_RST   = 32'd0;

	// request codes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;
	localparam logic POOL_DATA  = 1'b0;
	localparam logic POOL_INODE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic        mode;
		logic        pool;
		logic [31:0] number;
	} req_t;

	typedef struct packed {
		logic [31:0] granted;
		status_t     status;
	} rsp_t;

	typedef struct packed {
		logic [12:0] data_count;
		logic [10:0] inode_count;
		logic [31:0] data_base;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/bfa_map_ram.sv
`default_nettype none

module bfa_map_ram #(
	parameter int DEPTH  = 128,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 7
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/bfa_ffz.sv
`default_nettype none

module bfa_ffz #(
	parameter int WORD_BITS = 32,
	parameter int BP_W      = 5,
	parameter int AV_W      = 6
) (
	input  wire logic [WORD_BITS-1:0] word,
	input  wire logic [AV_W-1:0]      avail,
	output logic                      found,
	output logic      [BP_W-1:0]      pos,
	output logic      [WORD_BITS-1:0] onehot
);

	logic [WORD_BITS-1:0] valid;
	logic [WORD_BITS-1:0] free_bits;

	// mark bits that lie below the pool count
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			valid[j] = (AV_W'(j) < avail);
		end
	end

	// isolate the lowest clear bit
	assign free_bits = ~word & valid;
	assign onehot    = free_bits & (~free_bits + WORD_BITS'(1));
	assign found     = |free_bits;

	// encode the isolated bit
	always_comb begin
		pos = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (onehot[j]) begin
				pos = pos | BP_W'(j);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/bfa_regs.sv
`default_nettype none

module bfa_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [bfa_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [bfa_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [bfa_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                pready,
	output bfa_pkg::cfg_t                       cfg
);

	import bfa_pkg::*;

	logic [1:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel & penable & pwrite & pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.data_count  <= DATA_COUNT_RST;
			cfg.inode_count <= INODE_COUNT_RST;
			cfg.data_base   <= DATA_BASE_RST;
		end else if (wr) begin
			case (idx)
				REG_DATA_COUNT:  cfg.data_count  <= pwdata[12:0];
				REG_INODE_COUNT: cfg.inode_count <= pwdata[10:0];
				REG_DATA_BASE:   cfg.data_base   <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_DATA_COUNT:  prdata = CFG_DATA_W'(cfg.data_count);
			REG_INODE_COUNT: prdata = CFG_DATA_W'(cfg.inode_count);
			REG_DATA_BASE:   prdata = cfg.data_base;
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/bitmap_first_fit_allocator.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_req  (mode, pool, number)
// out       output     out_valid / out_stall out_rsp (granted, status)
// apb       input      psel/penable/pwrite  paddr, pwdata -> prdata, pready=1
//
// Allocate: S_START, then S_A_RD and S_A_CHK for each word scanned up to the first free bit,
// using the bitmap RAM read and the shared find-first-zero unit (up to 128 words by default).
// Free: S_START, then S_F_WALK for each word walked up to the word that holds the bit, then S_F_WR.
// After reset a clearing pass of max(data, inode) words (128 by default) runs before
// the first request is taken; register writes are taken during it.
// A result waits under out_stall; one new request is taken and held at completion meanwhile.
`default_nettype none

module bitmap_first_fit_allocator #(
	parameter int DATA_CAPACITY  = bfa_pkg::DATA_CAPACITY_DEF,
	parameter int INODE_CAPACITY = bfa_pkg::INODE_CAPACITY_DEF,
	parameter int WORD_BITS      = bfa_pkg::WORD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire bfa_pkg::req_t                  in_req,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output bfa_pkg::rsp_t                       out_rsp,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [bfa_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [bfa_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [bfa_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                pready
);

	import bfa_pkg::*;

	localparam int DATA_WORDS  = (DATA_CAPACITY + WORD_BITS - 1) / WORD_BITS;
	localparam int INODE_WORDS = (INODE_CAPACITY + WORD_BITS - 1) / WORD_BITS;
	localparam int MAX_WORDS   = (DATA_WORDS > INODE_WORDS) ? DATA_WORDS : INODE_WORDS;
	localparam int CAP_MAX     = (DATA_CAPACITY > INODE_CAPACITY) ? DATA_CAPACITY
	                                                              : INODE_CAPACITY;
	localparam int IDX_W = $clog2(CAP_MAX + WORD_BITS + 1);
	localparam int DA_W  = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
	localparam int IA_W  = (INODE_WORDS > 1) ? $clog2(INODE_WORDS) : 1;
	localparam int WA_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int BP_W  = $clog2(WORD_BITS);
	localparam int AV_W  = $clog2(WORD_BITS + 1);

	localparam logic [WA_W:0]   DATA_WORDS_C  = (WA_W + 1)'(DATA_WORDS);
	localparam logic [WA_W:0]   INODE_WORDS_C = (WA_W + 1)'(INODE_WORDS);
	localparam logic [WA_W-1:0] LAST_WORD     = WA_W'(MAX_WORDS - 1);
	localparam logic [IDX_W-1:0] WB_IDX       = IDX_W'(WORD_BITS);
	localparam logic [AV_W-1:0]  WB_AV        = AV_W'(WORD_BITS);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_A_RD,
		S_A_CHK,
		S_F_WALK,
		S_F_WR,
		S_DONE
	} state_t;

	state_t state_q;

	cfg_t cfg;

	req_t             req_q;
	logic [IDX_W-1:0] eff_q;
	logic [IDX_W-1:0] base_idx_q;
	logic [IDX_W-1:0] bit_q;
	logic [BP_W-1:0]  bitpos_q;
	logic [WA_W-1:0]  wcnt_q;
	logic [31:0]      res_granted_q;
	status_t          res_status_q;

	// configuration registers
	bfa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// effective count and base of the selected pool
	logic [31:0]      count32;
	logic [31:0]      cap32;
	logic [31:0]      eff32;
	logic [31:0]      base32;
	logic [31:0]      bit32;

	always_comb begin
		if (req_q.pool == POOL_INODE) begin
			count32 = 32'(cfg.inode_count);
			cap32   = 32'(INODE_CAPACITY);
			base32  = '0;
		end else begin
			count32 = 32'(cfg.data_count);
			cap32   = 32'(DATA_CAPACITY);
			base32  = cfg.data_base;
		end
		eff32 = (count32 > cap32) ? cap32 : count32;
		bit32 = req_q.number - base32;
	end

	// bitmap stores
	logic                 map_we;
	logic                 map_re;
	logic [WORD_BITS-1:0] map_wdata;
	logic                 data_we, inode_we, data_re, inode_re;
	logic [WORD_BITS-1:0] data_rdata, inode_rdata, rdata;
	logic                 clearing;

	assign clearing = (state_q == S_CLEAR);
	assign data_we  = clearing ? ({1'b0, wcnt_q} < DATA_WORDS_C)
	                           : (map_we && req_q.pool == POOL_DATA);
	assign inode_we = clearing ? ({1'b0, wcnt_q} < INODE_WORDS_C)
	                           : (map_we && req_q.pool == POOL_INODE);
	assign data_re  = map_re && req_q.pool == POOL_DATA;
	assign inode_re = map_re && req_q.pool == POOL_INODE;
	assign rdata    = (req_q.pool == POOL_INODE) ? inode_rdata : data_rdata;

	bfa_map_ram #(
		.DEPTH  (DATA_WORDS),
		.WIDTH  (WORD_BITS),
		.ADDR_W (DA_W)
	) u_data_map (
		.clk   (clk),
		.we    (data_we),
		.waddr (wcnt_q[DA_W-1:0]),
		.wdata (clearing ? '0 : map_wdata),
		.re    (data_re),
		.raddr (wcnt_q[DA_W-1:0]),
		.rdata (data_rdata)
	);

	bfa_map_ram #(
		.DEPTH  (INODE_WORDS),
		.WIDTH  (WORD_BITS),
		.ADDR_W (IA_W)
	) u_inode_map (
		.clk   (clk),
		.we    (inode_we),
		.waddr (wcnt_q[IA_W-1:0]),
		.wdata (clearing ? '0 : map_wdata),
		.re    (inode_re),
		.raddr (wcnt_q[IA_W-1:0]),
		.rdata (inode_rdata)
	);

	// shared find-first-zero over one word
	logic [IDX_W-1:0]     rem;
	logic [AV_W-1:0]      avail;
	logic                 ffz_found;
	logic [BP_W-1:0]      ffz_pos;
	logic [WORD_BITS-1:0] ffz_onehot;

	assign rem   = eff_q - base_idx_q;
	assign avail = (rem >= WB_IDX) ? WB_AV : rem[AV_W-1:0];

	bfa_ffz #(
		.WORD_BITS (WORD_BITS),
		.BP_W      (BP_W),
		.AV_W      (AV_W)
	) u_ffz (
		.word   (rdata),
		.avail  (avail),
		.found  (ffz_found),
		.pos    (ffz_pos),
		.onehot (ffz_onehot)
	);

	// word walk helpers
	logic [IDX_W-1:0] next_base;
	logic [IDX_W-1:0] off;
	logic [IDX_W-1:0] idx_sum;
	logic             slot_free;

	assign next_base = base_idx_q + WB_IDX;
	assign off       = bit_q - base_idx_q;
	assign idx_sum   = base_idx_q + IDX_W'(ffz_pos);
	assign slot_free = !out_valid || !out_stall;

	// store access strobes
	always_comb begin
		map_re    = 1'b0;
		map_we    = 1'b0;
		map_wdata = rdata;
		case (state_q)
			S_A_RD: begin
				map_re = 1'b1;
			end
			S_A_CHK: begin
				map_we    = ffz_found;
				map_wdata = rdata | ffz_onehot;
			end
			S_F_WALK: begin
				map_re = (off < WB_IDX);
			end
			S_F_WR: begin
				map_we    = 1'b1;
				map_wdata = rdata & ~(WORD_BITS'(1) << bitpos_q);
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			wcnt_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					wcnt_q <= wcnt_q + WA_W'(1);
					if (wcnt_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_req;
						state_q <= S_START;
					end
				end
				S_START: begin
					eff_q         <= eff32[IDX_W-1:0];
					bit_q         <= bit32[IDX_W-1:0];
					base_idx_q    <= '0;
					wcnt_q        <= '0;
					res_granted_q <= '0;
					if (req_q.mode == MODE_ALLOC) begin
						if (eff32 == '0) begin
							res_status_q <= ST_FULL;
							state_q      <= S_DONE;
						end else begin
							res_status_q <= ST_OK;
							state_q      <= S_A_RD;
						end
					end else if (bit32 >= eff32) begin
						res_status_q <= ST_RANGE;
						state_q      <= S_DONE;
					end else begin
						res_status_q <= ST_OK;
						state_q      <= S_F_WALK;
					end
				end
				S_A_RD: begin
					state_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (ffz_found) begin
						res_granted_q <= base32 + 32'(idx_sum);
						state_q       <= S_DONE;
					end else if (next_base >= eff_q) begin
						res_status_q <= ST_FULL;
						state_q      <= S_DONE;
					end else begin
						base_idx_q <= next_base;
						wcnt_q     <= wcnt_q + WA_W'(1);
						state_q    <= S_A_RD;
					end
				end
				S_F_WALK: begin
					if (off < WB_IDX) begin
						bitpos_q <= off[BP_W-1:0];
						state_q  <= S_F_WR;
					end else begin
						base_idx_q <= next_base;
						wcnt_q     <= wcnt_q + WA_W'(1);
					end
				end
				S_F_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						out_rsp.granted <= res_granted_q;
						out_rsp.status  <= res_status_q;
						out_valid       <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a grant carries a number only on success
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_rsp.status == ST_OK || out_rsp.granted == '0))
		else $error("nonzero grant with error status");

	// no store write while waiting for a request
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(data_we || inode_we))
		else $error("bitmap write while idle");

	// an accepted request starts work
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_START))
		else $error("accepted request not started");

	// the walk stays below the pool count
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_A_RD || state_q == S_A_CHK || state_q == S_F_WALK)
		|-> (base_idx_q < eff_q))
		else $error("word walk past pool count");

endmodule

`default_nettype wire
